FILE: hdl/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// Types, constants and the divide-by-nine helper for the 3x3 box blur.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int WIDTH  = 1024;
  localparam int HEIGHT = 768;

  localparam int COL_W  = $clog2(WIDTH);
  localparam int ROW_W  = $clog2(HEIGHT + 2);
  localparam int PIX_W  = 24;
  localparam int CSUM_W = 10;
  localparam int SUM_W  = 12;
  localparam int LINE_W = 2 * PIX_W;

  localparam logic [12:0] RECIP_9 = 13'd7282;
  localparam logic [7:0]  ALPHA   = 8'hFF;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        flush;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic col_zero;
    logic use_a;
    logic use_b;
    logic emit;
    logic last;
  } s1_ctrl_t;

  typedef struct packed {
    logic [CSUM_W-1:0] r;
    logic [CSUM_W-1:0] g;
    logic [CSUM_W-1:0] b;
  } col_sum_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } win_sum_t;

  // Exact floor(x / 9) for x up to 9 * 255.
  function automatic logic [7:0] div9(input logic [SUM_W-1:0] x);
    logic [SUM_W+12:0] prod;
    prod = {13'd0, x} * {{SUM_W{1'b0}}, RECIP_9};
    return prod[23:16];
  endfunction

endpackage

FILE: hdl/rbb_ram.sv
// ----------------------------------------------------------------------------
// rbb_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rbb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/rbb_window.sv
// ----------------------------------------------------------------------------
// rbb_window
// Takes the line store read, writes the shifted column back and keeps the
// 3x3 window as per-column channel sums, registering the window total.
// ----------------------------------------------------------------------------
module rbb_window
  import rbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  s1_ctrl_t          s1,
  input  logic [PIX_W-1:0]  s1_pix,
  input  logic [LINE_W-1:0] rd_data,
  output logic              wr_en,
  output logic [LINE_W-1:0] wr_data,
  output win_sum_t          sum_o
);

  logic [PIX_W-1:0] a_old;
  logic [PIX_W-1:0] b_old;
  logic [PIX_W-1:0] col0;
  logic [PIX_W-1:0] col1;
  col_sum_t         cs;
  col_sum_t         w1_r, w1_nxt;
  col_sum_t         w2_r, w2_nxt;
  win_sum_t         sum_r, sum_nxt;

  function automatic logic [CSUM_W-1:0] ch3(input logic [7:0] x, input logic [7:0] y,
                                           input logic [7:0] z);
    return CSUM_W'(x) + CSUM_W'(y) + CSUM_W'(z);
  endfunction

  always_comb begin
    a_old   = rd_data[PIX_W-1:0];
    b_old   = rd_data[LINE_W-1:PIX_W];
    col0    = s1.use_b ? b_old : '0;
    col1    = s1.use_a ? a_old : '0;
    wr_en   = en && s1.valid;
    wr_data = {a_old, s1_pix};

    cs.r = ch3(col0[23:16], col1[23:16], s1_pix[23:16]);
    cs.g = ch3(col0[15:8],  col1[15:8],  s1_pix[15:8]);
    cs.b = ch3(col0[7:0],   col1[7:0],   s1_pix[7:0]);

    w1_nxt = w1_r;
    w2_nxt = w2_r;
    if (en && s1.valid) begin
      w1_nxt = s1.col_zero ? '0 : w2_r;
      w2_nxt = cs;
    end

    sum_nxt = sum_r;
    if (en) begin
      sum_nxt.valid = s1.valid && s1.emit;
      sum_nxt.last  = s1.last;
      sum_nxt.r = SUM_W'(w1_r.r) + SUM_W'(w2_r.r) + (s1.col_zero ? '0 : SUM_W'(cs.r));
      sum_nxt.g = SUM_W'(w1_r.g) + SUM_W'(w2_r.g) + (s1.col_zero ? '0 : SUM_W'(cs.g));
      sum_nxt.b = SUM_W'(w1_r.b) + SUM_W'(w2_r.b) + (s1.col_zero ? '0 : SUM_W'(cs.b));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r        <= '0;
      w2_r        <= '0;
      sum_r.valid <= 1'b0;
      sum_r.last  <= 1'b0;
    end else begin
      w1_r        <= w1_nxt;
      w2_r        <= w2_nxt;
      sum_r.valid <= sum_nxt.valid;
      sum_r.last  <= sum_nxt.last;
    end
    sum_r.r <= sum_nxt.r;
    sum_r.g <= sum_nxt.g;
    sum_r.b <= sum_nxt.b;
  end

  assign sum_o = sum_r;

endmodule

FILE: hdl/rbb_out_buf.sv
// ----------------------------------------------------------------------------
// rbb_out_buf
// Divides the window totals by nine and holds results in an output register
// backed by a skid register.
// ----------------------------------------------------------------------------
module rbb_out_buf
  import rbb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  win_sum_t  sum_i,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t q;
  out_item_t o_r, o_nxt;
  out_item_t skid_r, skid_nxt;
  logic      o_valid_r, o_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  logic      take;

  always_comb begin
    q.out_word     = {div9(sum_i.r), div9(sum_i.g), div9(sum_i.b), ALPHA};
    q.end_of_frame = sum_i.last;
    take           = sum_i.valid && !skid_valid_r;

    o_nxt          = o_r;
    skid_nxt       = skid_r;
    o_valid_nxt    = o_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_ready) begin
        o_nxt          = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (take) begin
      if (!o_valid_r || out_ready) begin
        o_nxt       = q;
        o_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = q;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r    <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      o_valid_r    <= o_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    o_r    <= o_nxt;
    skid_r <= skid_nxt;
  end

  assign space     = !skid_valid_r;
  assign out_valid = o_valid_r;
  assign out_data  = o_r;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> o_valid_r)
    else $error("Skid register holds an item while the output register is empty.");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(o_valid_r && !out_ready))
    else $error("Skid register filled although the output register could move.");
`endif

endmodule

FILE: hdl/rgb_box_blur_3x3.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// Streaming 3x3 box blur over RGBA pixels in raster order, with both line
// stores packed side by side in one RAM.
//
// Channel   Ports                          Direction
// in        in_valid in_ready in_data      input items (pixel, flush)
// out       out_valid out_ready out_data   result items (pixel, end of frame)
//
// One item is accepted every clock unless stalled; the line store is read at
// the accepted column and written back from the first stage registers, so
// successive items never collide. A result passes the first stage, window
// sum and output registers; the first WIDTH+1 items of a frame give no result.
// Reset clears the counters, window and pipeline; the line store is not cleared.
// in_ready falls only while the output skid register is occupied.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3
  import rbb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              accept;
  logic              en;
  logic              last;
  s1_ctrl_t          s1_r, s1_nxt;
  logic [COL_W-1:0]  s1_addr_r, s1_addr_nxt;
  logic [PIX_W-1:0]  s1_pix_r, s1_pix_nxt;
  logic [LINE_W-1:0] rd_data;
  logic              wr_en;
  logic [LINE_W-1:0] wr_data;
  win_sum_t          win_sum;

  assign accept   = in_valid && in_ready;
  assign in_ready = en;

  always_comb begin
    last        = (row_r == ROW_W'(HEIGHT + 1));
    col_nxt     = col_r;
    row_nxt     = row_r;
    s1_nxt      = s1_r;
    s1_addr_nxt = s1_addr_r;
    s1_pix_nxt  = s1_pix_r;
    if (en) begin
      s1_nxt.valid    = accept;
      s1_nxt.col_zero = (col_r == '0);
      s1_nxt.use_a    = (row_r >= ROW_W'(1));
      s1_nxt.use_b    = (row_r >= ROW_W'(2));
      s1_nxt.emit     = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
      s1_nxt.last     = last;
      s1_addr_nxt     = col_r;
      s1_pix_nxt      = (!in_data.flush && (row_r < ROW_W'(HEIGHT))) ?
                        in_data.pixel_word[31:8] : '0;
    end
    if (accept) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == COL_W'(WIDTH - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      s1_r  <= s1_nxt;
    end
    s1_addr_r <= s1_addr_nxt;
    s1_pix_r  <= s1_pix_nxt;
  end

  rbb_ram #(
    .DATA_W (LINE_W),
    .DEPTH  (WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (rd_data)
  );

  rbb_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .s1      (s1_r),
    .s1_pix  (s1_pix_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .sum_o   (win_sum)
  );

  rbb_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_i     (win_sum),
    .space     (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(WIDTH - 1))
    else $error("Column counter ran past the last column.");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_W'(HEIGHT + 1))
    else $error("Row counter ran past the drain row.");

  a_s1_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_r.valid)
    else $error("Accepted item did not reach the first pipeline stage.");
`endif

endmodule
